// File: design/fds_pkg.sv
// ----------------------------------------------------------------------------
// fds_pkg
// Shared types, codes and reset values for the feeder dispense sequencer.
// ----------------------------------------------------------------------------
package fds_pkg;

  localparam int TURN_W    = 16;
  localparam int TIMER_W   = 16;
  localparam int ELAPSED_W = 32;
  localparam int COUNT_W   = 16;
  localparam int PAUSE_W   = 8;
  localparam int JAM_W     = 12;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 20;
  localparam int MOD_STEPS = TURN_W;
  localparam int MOD_CNT_W = $clog2(MOD_STEPS);

  // register reset values
  localparam logic [7:0]  RST_STEP_PERIOD = 8'd2;
  localparam logic [7:0]  RST_PAUSE_EVERY = 8'd25;
  localparam logic [15:0] RST_PAUSE_MS    = 16'd1000;
  localparam logic [11:0] RST_MINOR_EVERY = 12'd100;
  localparam logic [11:0] RST_VIB_EVERY   = 12'd200;
  localparam logic [15:0] RST_MAX_TURNS   = 16'd2000;
  localparam logic [15:0] RST_SETTLE_MS   = 16'd500;
  localparam logic [19:0] RST_RETRIEVE_MS = 20'd20000;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_LATE  = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_DROP      = 3'd1,
    EV_NOT_DET   = 3'd2,
    EV_TAKEN     = 3'd3,
    EV_PEND_LATE = 3'd4,
    EV_LATE_TAKEN = 3'd5,
    EV_JAMMED    = 3'd6
  } event_t;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_DISP      = 3'd1,
    PH_PAUSE     = 3'd2,
    PH_PAUSE_RDY = 3'd3,
    PH_SETTLE    = 3'd4,
    PH_WELL      = 3'd5
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_PERIOD = 3'd0,
    REG_PAUSE_EVERY = 3'd1,
    REG_PAUSE_MS    = 3'd2,
    REG_MINOR_EVERY = 3'd3,
    REG_VIB_EVERY   = 3'd4,
    REG_MAX_TURNS   = 3'd5,
    REG_SETTLE_MS   = 3'd6,
    REG_RETRIEVE_MS = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SEL_PAUSE = 2'd0,
    SEL_MINOR = 2'd1,
    SEL_VIB   = 2'd2
  } mod_sel_t;

  typedef struct packed {
    logic [7:0]  step_period_ms;
    logic [7:0]  pause_every_turns;
    logic [15:0] pause_ms;
    logic [11:0] minor_jam_every;
    logic [11:0] vibrate_jam_every;
    logic [15:0] max_turns;
    logic [15:0] settle_window_ms;
    logic [19:0] retrieval_window_ms;
  } cfg_t;

  typedef struct packed {
    logic            valid;
    mod_sel_t        sel;
    logic [JAM_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic            valid;
    mod_sel_t        sel;
    logic [JAM_W-1:0] rem;
  } mod_rsp_t;

  typedef struct packed {
    logic                 motor_step;
    logic                 motor_release;
    logic                 minor_jam_clear;
    logic                 vibrate_jam_clear;
    event_t               event_code;
    logic [ELAPSED_W-1:0] retrieval_ms;
    logic [COUNT_W-1:0]   pellet_count;
    logic                 busy_res;
  } result_t;

endpackage

// File: design/fds_mod_unit.sv
// ----------------------------------------------------------------------------
// fds_mod_unit
// Bit-serial remainder of the turn count by a new turn multiple.
// ----------------------------------------------------------------------------
module fds_mod_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  fds_pkg::mod_req_t           req,
  input  logic [fds_pkg::TURN_W-1:0]  dividend,
  output logic                        busy,
  output fds_pkg::mod_rsp_t           rsp
);
  import fds_pkg::*;

  logic [MOD_CNT_W-1:0] cnt;
  logic [TURN_W-1:0]    dvd;
  logic [JAM_W-1:0]     dvs;
  logic [JAM_W-1:0]     rem;
  mod_sel_t             sel;
  logic [JAM_W:0]       rem_sh;
  logic [JAM_W:0]       rem_step;

  // one quotient bit per cycle, msb first
  always_comb begin
    rem_sh = {rem, dvd[TURN_W-1]};
    if (rem_sh >= {1'b0, dvs}) begin
      rem_step = rem_sh - {1'b0, dvs};
    end else begin
      rem_step = rem_sh;
    end
    rsp.valid = busy && (cnt == MOD_CNT_W'(MOD_STEPS - 1));
    rsp.sel   = sel;
    rsp.rem   = rem_step[JAM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.valid && !busy) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == MOD_CNT_W'(MOD_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && !busy) begin
      dvd <= dividend;
      dvs <= req.divisor;
      sel <= req.sel;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[TURN_W-2:0], 1'b0};
      rem <= rem_step[JAM_W-1:0];
    end
  end

endmodule

// File: design/fds_cfg_regs.sv
// ----------------------------------------------------------------------------
// fds_cfg_regs
// Configuration register file; a new turn multiple requests a remainder update.
// ----------------------------------------------------------------------------
module fds_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [fds_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [fds_pkg::CFG_DAT_W-1:0]  wr_data,
  output fds_pkg::cfg_t                  cfg,
  output fds_pkg::mod_req_t              mod_req
);
  import fds_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_period_ms      <= RST_STEP_PERIOD;
      cfg.pause_every_turns   <= RST_PAUSE_EVERY;
      cfg.pause_ms            <= RST_PAUSE_MS;
      cfg.minor_jam_every     <= RST_MINOR_EVERY;
      cfg.vibrate_jam_every   <= RST_VIB_EVERY;
      cfg.max_turns           <= RST_MAX_TURNS;
      cfg.settle_window_ms    <= RST_SETTLE_MS;
      cfg.retrieval_window_ms <= RST_RETRIEVE_MS;
    end else if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        REG_STEP_PERIOD: cfg.step_period_ms      <= wr_data[7:0];
        REG_PAUSE_EVERY: cfg.pause_every_turns   <= wr_data[PAUSE_W-1:0];
        REG_PAUSE_MS:    cfg.pause_ms            <= wr_data[15:0];
        REG_MINOR_EVERY: cfg.minor_jam_every     <= wr_data[JAM_W-1:0];
        REG_VIB_EVERY:   cfg.vibrate_jam_every   <= wr_data[JAM_W-1:0];
        REG_MAX_TURNS:   cfg.max_turns           <= wr_data[15:0];
        REG_SETTLE_MS:   cfg.settle_window_ms    <= wr_data[15:0];
        REG_RETRIEVE_MS: cfg.retrieval_window_ms <= wr_data[19:0];
        default: ;
      endcase
    end
  end

  // remainder refresh for the three turn multiples
  always_comb begin
    mod_req = '0;
    case (cfg_reg_t'(wr_index))
      REG_PAUSE_EVERY: begin
        mod_req.valid   = wr_en;
        mod_req.sel     = SEL_PAUSE;
        mod_req.divisor = {{(JAM_W-PAUSE_W){1'b0}}, wr_data[PAUSE_W-1:0]};
      end
      REG_MINOR_EVERY: begin
        mod_req.valid   = wr_en;
        mod_req.sel     = SEL_MINOR;
        mod_req.divisor = wr_data[JAM_W-1:0];
      end
      REG_VIB_EVERY: begin
        mod_req.valid   = wr_en;
        mod_req.sel     = SEL_VIB;
        mod_req.divisor = wr_data[JAM_W-1:0];
      end
      default: ;
    endcase
  end

endmodule

// File: design/fds_seq_core.sv
// ----------------------------------------------------------------------------
// fds_seq_core
// Feed state and the per-item next-state and result logic.
// ----------------------------------------------------------------------------
module fds_seq_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_en,
  input  fds_pkg::func_t              func,
  input  logic                        sensed,
  input  logic                        over,
  input  fds_pkg::cfg_t               cfg,
  input  fds_pkg::mod_rsp_t           mod_rsp,
  output logic [fds_pkg::TURN_W-1:0]  turn_count,
  output fds_pkg::result_t            res
);
  import fds_pkg::*;

  phase_t               phase, phase_next;
  logic [TURN_W-1:0]    turn_count_next;
  logic [TIMER_W-1:0]   phase_timer, phase_timer_next;
  logic [ELAPSED_W-1:0] well_elapsed, well_elapsed_next;
  logic [COUNT_W-1:0]   pellet_total, pellet_total_next;
  logic                 late_pending, late_pending_next;
  // turn count modulo each turn multiple
  logic [PAUSE_W-1:0]   pause_res, pause_res_next;
  logic [JAM_W-1:0]     minor_res, minor_res_next;
  logic [JAM_W-1:0]     vib_res, vib_res_next;

  logic [TIMER_W:0]     timer_inc;
  logic [ELAPSED_W-1:0] we_inc;
  logic                 turn_inc;
  logic [PAUSE_W:0]     pause_up;
  logic [JAM_W:0]       minor_up;
  logic [JAM_W:0]       vib_up;
  logic                 pause_hit;
  logic                 seen;

  always_comb begin
    phase_next        = phase;
    turn_count_next   = turn_count;
    phase_timer_next  = phase_timer;
    well_elapsed_next = well_elapsed;
    pellet_total_next = pellet_total;
    late_pending_next = late_pending;
    pause_res_next    = pause_res;
    minor_res_next    = minor_res;
    vib_res_next      = vib_res;
    res               = '0;
    res.event_code    = EV_NONE;

    timer_inc = {1'b0, phase_timer} + 1'b1;
    if ((late_pending || phase == PH_WELL) && (well_elapsed != '1)) begin
      we_inc = well_elapsed + 1'b1;
    end else begin
      we_inc = well_elapsed;
    end
    seen      = sensed || over;
    turn_inc  = (turn_count != '1);
    pause_up  = {1'b0, pause_res} + 1'b1;
    minor_up  = {1'b0, minor_res} + 1'b1;
    vib_up    = {1'b0, vib_res} + 1'b1;
    pause_hit = 1'b0;

    if (item_en) begin
      case (func)
        FUNC_TICK: begin
          well_elapsed_next = we_inc;
          case (phase)
            PH_DISP: begin
              if (phase_timer == '0) begin
                res.motor_step = 1'b1;
                if (turn_inc) begin
                  turn_count_next = turn_count + 1'b1;
                  pause_res_next  = (pause_up == {1'b0, cfg.pause_every_turns}) ?
                                    '0 : pause_up[PAUSE_W-1:0];
                  minor_res_next  = (minor_up == {1'b0, cfg.minor_jam_every}) ?
                                    '0 : minor_up[JAM_W-1:0];
                  vib_res_next    = (vib_up == {1'b0, cfg.vibrate_jam_every}) ?
                                    '0 : vib_up[JAM_W-1:0];
                end
                pause_hit = (cfg.pause_every_turns != '0) && (pause_res_next == '0);
                res.motor_release     = pause_hit;
                res.minor_jam_clear   = (cfg.minor_jam_every != '0) &&
                                        (minor_res_next == '0);
                res.vibrate_jam_clear = (cfg.vibrate_jam_every != '0) &&
                                        (vib_res_next == '0);
                if (turn_count_next > cfg.max_turns) begin
                  res.event_code    = EV_JAMMED;
                  res.motor_release = 1'b1;
                  phase_next        = PH_IDLE;
                  phase_timer_next  = '0;
                end else if (pause_hit) begin
                  phase_next       = seen ? PH_PAUSE_RDY : PH_PAUSE;
                  phase_timer_next = '0;
                end else if (seen) begin
                  res.motor_release = 1'b1;
                  res.event_code    = EV_DROP;
                  pellet_total_next = pellet_total + 1'b1;
                  phase_next        = PH_SETTLE;
                  phase_timer_next  = '0;
                end
              end
              if (phase_next == PH_DISP) begin
                phase_timer_next = (timer_inc >= {{(TIMER_W-7){1'b0}}, cfg.step_period_ms})
                                   ? '0 : timer_inc[TIMER_W-1:0];
              end
            end
            PH_PAUSE, PH_PAUSE_RDY: begin
              if (timer_inc >= {1'b0, cfg.pause_ms}) begin
                phase_timer_next = '0;
                if (phase == PH_PAUSE_RDY) begin
                  res.motor_release = 1'b1;
                  res.event_code    = EV_DROP;
                  pellet_total_next = pellet_total + 1'b1;
                  phase_next        = PH_SETTLE;
                end else begin
                  phase_next = PH_DISP;
                end
              end else begin
                phase_timer_next = timer_inc[TIMER_W-1:0];
              end
            end
            PH_SETTLE: begin
              if (sensed) begin
                phase_next        = PH_WELL;
                phase_timer_next  = '0;
                well_elapsed_next = '0;
              end else if (timer_inc >= {1'b0, cfg.settle_window_ms}) begin
                res.event_code   = EV_NOT_DET;
                phase_next       = PH_IDLE;
                phase_timer_next = '0;
              end else begin
                phase_timer_next = timer_inc[TIMER_W-1:0];
              end
            end
            PH_WELL: begin
              if (!sensed) begin
                res.event_code    = EV_TAKEN;
                res.retrieval_ms  = we_inc;
                late_pending_next = 1'b0;
                phase_next        = PH_IDLE;
              end else if (we_inc > {{(ELAPSED_W-20){1'b0}}, cfg.retrieval_window_ms}) begin
                res.event_code    = EV_PEND_LATE;
                late_pending_next = 1'b1;
                phase_next        = PH_IDLE;
              end
            end
            default: begin
              phase_next = PH_IDLE;
            end
          endcase
        end
        FUNC_START: begin
          if (phase == PH_IDLE) begin
            if (late_pending && !sensed) begin
              res.event_code    = EV_LATE_TAKEN;
              res.retrieval_ms  = well_elapsed;
              late_pending_next = 1'b0;
            end
            turn_count_next  = '0;
            pause_res_next   = '0;
            minor_res_next   = '0;
            vib_res_next     = '0;
            phase_timer_next = '0;
            phase_next       = PH_DISP;
          end
        end
        FUNC_LATE: begin
          if (late_pending && !sensed) begin
            res.event_code    = EV_LATE_TAKEN;
            res.retrieval_ms  = well_elapsed;
            late_pending_next = 1'b0;
          end
        end
        default: ;
      endcase
    end

    // remainder refresh after a turn multiple is rewritten
    if (mod_rsp.valid) begin
      case (mod_rsp.sel)
        SEL_PAUSE: pause_res_next = mod_rsp.rem[PAUSE_W-1:0];
        SEL_MINOR: minor_res_next = mod_rsp.rem;
        SEL_VIB:   vib_res_next   = mod_rsp.rem;
        default: ;
      endcase
    end

    res.pellet_count = pellet_total_next;
    res.busy_res     = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      turn_count   <= '0;
      phase_timer  <= '0;
      well_elapsed <= '0;
      pellet_total <= '0;
      late_pending <= 1'b0;
      pause_res    <= '0;
      minor_res    <= '0;
      vib_res      <= '0;
    end else begin
      phase        <= phase_next;
      turn_count   <= turn_count_next;
      phase_timer  <= phase_timer_next;
      well_elapsed <= well_elapsed_next;
      pellet_total <= pellet_total_next;
      late_pending <= late_pending_next;
      pause_res    <= pause_res_next;
      minor_res    <= minor_res_next;
      vib_res      <= vib_res_next;
    end
  end

endmodule

// File: design/feeder_dispense_sequencer.sv
// an input transfer lands in the input register, and its result then in the result register
// throughput: one item per cycle while out_ready is high and no remainder update runs
// writing a turn multiple (registers 1, 3, 4) starts a bit-serial remainder update;
// in_ready and cfg_ready stay low until it ends
// reset: synchronous active-high rst, phase idle, counters zero, registers to defaults
// ----------------------------------------------------------------------------
// feeder_dispense_sequencer
// Pellet dispenser feed sequencer stepped by millisecond tick items.
// ----------------------------------------------------------------------------
module feeder_dispense_sequencer (
  input  logic                           clk,
  input  logic                           rst,
  // item input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     func,
  input  logic                           pellet_sensed,
  input  logic                           override_button,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           motor_step,
  output logic                           motor_release,
  output logic                           minor_jam_clear,
  output logic                           vibrate_jam_clear,
  output logic [2:0]                     event_code,
  output logic [31:0]                    retrieval_ms,
  output logic [15:0]                    pellet_count,
  output logic                           busy_res,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fds_pkg::CFG_DAT_W-1:0]  cfg_data
);
  import fds_pkg::*;

  // input register
  logic              s1_valid;
  func_t             s1_func;
  logic              s1_sensed;
  logic              s1_over;
  // handshake control
  logic              advance;
  logic              item_en;
  logic              mod_busy;
  // datapath between units
  cfg_t              cfg;
  mod_req_t          mod_req;
  mod_rsp_t          mod_rsp;
  logic [TURN_W-1:0] turn_count;
  result_t           res_comb;
  result_t           res;

  // result register can take a new value when empty or being drained
  assign advance   = !out_valid || out_ready;
  assign item_en   = s1_valid && advance;
  // no transfers while the remainder unit rewrites a turn residue
  assign in_ready  = !mod_busy && (!s1_valid || advance);
  assign cfg_ready = !mod_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_func   <= func_t'(func);
      s1_sensed <= pellet_sensed;
      s1_over   <= override_button;
    end
  end

  fds_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg),
    .mod_req  (mod_req)
  );

  fds_mod_unit u_mod (
    .clk      (clk),
    .rst      (rst),
    .req      (mod_req),
    .dividend (turn_count),
    .busy     (mod_busy),
    .rsp      (mod_rsp)
  );

  fds_seq_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_en    (item_en),
    .func       (s1_func),
    .sensed     (s1_sensed),
    .over       (s1_over),
    .cfg        (cfg),
    .mod_rsp    (mod_rsp),
    .turn_count (turn_count),
    .res        (res_comb)
  );

  // result register, one result per item
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_en) begin
      res <= res_comb;
    end
  end

  assign motor_step        = res.motor_step;
  assign motor_release     = res.motor_release;
  assign minor_jam_clear   = res.minor_jam_clear;
  assign vibrate_jam_clear = res.vibrate_jam_clear;
  assign event_code        = res.event_code;
  assign retrieval_ms      = res.retrieval_ms;
  assign pellet_count      = res.pellet_count;
  assign busy_res          = res.busy_res;

`ifndef ASSERT_OFF
  // a jam always releases the motor and ends the feed
  a_jam_release: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_code == EV_JAMMED) |-> (motor_release && !busy_res))
    else $error("jammed result without release or with busy set");

  // retrieval time only travels with the taken events
  a_ret_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_code != EV_TAKEN && event_code != EV_LATE_TAKEN)
      |-> (retrieval_ms == '0))
    else $error("retrieval time on a non-retrieval event");

  // no item enters while a turn residue is being rebuilt
  a_mod_block: assert property (@(posedge clk) disable iff (rst)
    mod_busy |-> (!in_ready && !cfg_ready))
    else $error("transfer allowed during remainder update");

  // a drop result carries the pellet count that the core computed for it
  a_drop_count: assert property (@(posedge clk) disable iff (rst)
    item_en |=> (event_code != EV_DROP) ||
                (pellet_count == $past(u_core.res.pellet_count)))
    else $error("drop result pellet count mismatch");
`endif

endmodule

// File: verif/tb_feeder_dispense_sequencer.sv
// ----------------------------------------------------------------------------
// tb_feeder_dispense_sequencer
// Self-checking bench for the feeder dispense sequencer. An in-bench model of
// the feed phases predicts one result per input transfer; a checker compares
// each result transfer field by field. Directed feeds come first, then long
// runs of well-formed random feeds under several register settings, with
// random idling on both channels and one long result-side hold.
// ----------------------------------------------------------------------------
module tb_feeder_dispense_sequencer;
  import fds_pkg::*;

  localparam int LIMIT_CYCLES = 500000;
  localparam int DRAIN_CYCLES = 8;     // margin after the last expected result is back
  localparam int LONG_HOLD    = 200;   // result-side hold while items keep coming
  localparam int MAX_REPORTS  = 100;
  localparam int BURST_TICKS  = 60;    // plain ticks sent with no idling
  localparam int RANDOM_ITEMS = 110;   // random items per register setting

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  func = FUNC_TICK;
  logic        pellet_sensed = 1'b0;
  logic        override_button = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        motor_step;
  logic        motor_release;
  logic        minor_jam_clear;
  logic        vibrate_jam_clear;
  logic [2:0]  event_code;
  logic [31:0] retrieval_ms;
  logic [15:0] pellet_count;
  logic        busy_res;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_STEP_PERIOD;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  feeder_dispense_sequencer dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .func              (func),
    .pellet_sensed     (pellet_sensed),
    .override_button   (override_button),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .motor_step        (motor_step),
    .motor_release     (motor_release),
    .minor_jam_clear   (minor_jam_clear),
    .vibrate_jam_clear (vibrate_jam_clear),
    .event_code        (event_code),
    .retrieval_ms      (retrieval_ms),
    .pellet_count      (pellet_count),
    .busy_res          (busy_res),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // idling knobs, changed by the tests between phases
  int tx_gap_max = 10;
  int rx_stall_max = 10;
  bit long_hold_req = 1'b0;

  int mismatches = 0;
  int results_checked = 0;
  int cycle_count = 0;

  // expected results, oldest first
  result_t expected_results[$];

  // ---------------------------------------------------------------------------
  // sequencer model: registers and feed state as the block should hold them
  // ---------------------------------------------------------------------------
  cfg_t         settings;
  phase_t       seq_phase = PH_IDLE;
  logic [15:0]  turn_total = '0;
  int unsigned  phase_ticks = 0;
  logic [31:0]  well_ticks = '0;
  logic [15:0]  pellets_out = '0;
  logic         late_open = 1'b0;
  result_t      next_result;

  // pellet leaves the dispenser: release, count it, wait for it in the well
  function automatic void pellet_drop();
    next_result.motor_release = 1'b1;
    pellets_out = pellets_out + 16'd1;
    next_result.event_code = EV_DROP;
    seq_phase = PH_SETTLE;
    phase_ticks = 0;
  endfunction

  // an overdue removal is reported once the well reads empty
  function automatic void late_removal_check(logic sensed);
    if (late_open && !sensed) begin
      next_result.event_code = EV_LATE_TAKEN;
      next_result.retrieval_ms = well_ticks;
      late_open = 1'b0;
    end
  endfunction

  function automatic void advance_sequencer(func_t op, logic sensed, logic over);
    logic pause_turn;
    next_result = '0;
    next_result.event_code = EV_NONE;
    case (op)
      FUNC_TICK: begin
        // well time runs in the well and while a late removal is open
        if ((late_open || seq_phase == PH_WELL) && well_ticks != '1) begin
          well_ticks = well_ticks + 32'd1;
        end
        case (seq_phase)
          PH_DISP: begin
            if (phase_ticks == 0) begin
              next_result.motor_step = 1'b1;
              if (turn_total != '1) turn_total = turn_total + 16'd1;
              pause_turn = settings.pause_every_turns != 0 &&
                           (turn_total % settings.pause_every_turns) == 0;
              if (pause_turn) next_result.motor_release = 1'b1;
              if (settings.minor_jam_every != 0 &&
                  (turn_total % settings.minor_jam_every) == 0) begin
                next_result.minor_jam_clear = 1'b1;
              end
              if (settings.vibrate_jam_every != 0 &&
                  (turn_total % settings.vibrate_jam_every) == 0) begin
                next_result.vibrate_jam_clear = 1'b1;
              end
              // jam beats both a pause and a pellet seen
              if (turn_total > settings.max_turns) begin
                next_result.event_code = EV_JAMMED;
                next_result.motor_release = 1'b1;
                seq_phase = PH_IDLE;
                phase_ticks = 0;
              end else if (pause_turn) begin
                seq_phase = (sensed || over) ? PH_PAUSE_RDY : PH_PAUSE;
                phase_ticks = 0;
              end else if (sensed || over) begin
                pellet_drop();
              end
            end
            if (seq_phase == PH_DISP) begin
              phase_ticks = phase_ticks + 1;
              if (phase_ticks >= settings.step_period_ms) phase_ticks = 0;
            end
          end
          PH_PAUSE, PH_PAUSE_RDY: begin
            phase_ticks = phase_ticks + 1;
            if (phase_ticks >= settings.pause_ms) begin
              if (seq_phase == PH_PAUSE_RDY) begin
                pellet_drop();
              end else begin
                seq_phase = PH_DISP;
                phase_ticks = 0;
              end
            end
          end
          PH_SETTLE: begin
            if (sensed) begin
              seq_phase = PH_WELL;
              phase_ticks = 0;
              well_ticks = '0;
            end else begin
              phase_ticks = phase_ticks + 1;
              if (phase_ticks >= settings.settle_window_ms) begin
                next_result.event_code = EV_NOT_DET;
                seq_phase = PH_IDLE;
                phase_ticks = 0;
              end
            end
          end
          PH_WELL: begin
            if (!sensed) begin
              next_result.event_code = EV_TAKEN;
              next_result.retrieval_ms = well_ticks;
              late_open = 1'b0;
              seq_phase = PH_IDLE;
            end else if (well_ticks > settings.retrieval_window_ms) begin
              next_result.event_code = EV_PEND_LATE;
              late_open = 1'b1;
              seq_phase = PH_IDLE;
            end
          end
          default: begin
            seq_phase = PH_IDLE;
          end
        endcase
      end
      FUNC_START: begin
        // a start while busy is dropped without effect
        if (seq_phase == PH_IDLE) begin
          late_removal_check(sensed);
          turn_total = '0;
          phase_ticks = 0;
          seq_phase = PH_DISP;
        end
      end
      FUNC_LATE: begin
        late_removal_check(sensed);
      end
      default: begin
      end
    endcase
    next_result.pellet_count = pellets_out;
    next_result.busy_res = (seq_phase != PH_IDLE);
  endfunction

  // ---------------------------------------------------------------------------
  // clock, cycle limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result side: random stalls after each transfer, one long hold on request
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    while (rst) @(posedge clk);
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      stall = 0;
      if (long_hold_req) begin
        stall = LONG_HOLD;
        long_hold_req = 1'b0;
      end else if (out_valid && out_ready) begin
        stall = $urandom_range(0, rx_stall_max);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // checker
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("MISMATCH at result %0d: %s", results_checked, msg);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else begin
        want = expected_results.pop_front();
        if (motor_step !== want.motor_step)
          report_mismatch($sformatf("motor_step got %0d want %0d",
                                    motor_step, want.motor_step));
        if (motor_release !== want.motor_release)
          report_mismatch($sformatf("motor_release got %0d want %0d",
                                    motor_release, want.motor_release));
        if (minor_jam_clear !== want.minor_jam_clear)
          report_mismatch($sformatf("minor_jam_clear got %0d want %0d",
                                    minor_jam_clear, want.minor_jam_clear));
        if (vibrate_jam_clear !== want.vibrate_jam_clear)
          report_mismatch($sformatf("vibrate_jam_clear got %0d want %0d",
                                    vibrate_jam_clear, want.vibrate_jam_clear));
        if (event_code !== want.event_code)
          report_mismatch($sformatf("event_code got %0d want %0d",
                                    event_code, want.event_code));
        if (retrieval_ms !== want.retrieval_ms)
          report_mismatch($sformatf("retrieval_ms got %0d want %0d",
                                    retrieval_ms, want.retrieval_ms));
        if (pellet_count !== want.pellet_count)
          report_mismatch($sformatf("pellet_count got %0d want %0d",
                                    pellet_count, want.pellet_count));
        if (busy_res !== want.busy_res)
          report_mismatch($sformatf("busy_res got %0d want %0d",
                                    busy_res, want.busy_res));
      end
      results_checked++;
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // one item: optional idle gap, then hold valid until the transfer; valid is
  // left high so a back-to-back item needs no drop
  task automatic send_item(func_t op, logic sensed, logic over);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= op;
    pellet_sensed <= sensed;
    override_button <= over;
    do @(posedge clk); while (!in_ready);
    advance_sequencer(op, sensed, over);
    expected_results.push_back(next_result);
  endtask

  task automatic send_ticks(int count, logic sensed, logic over);
    repeat (count) send_item(FUNC_TICK, sensed, over);
  endtask

  // photogate on until the pellet lands, then off so it is taken
  task automatic complete_feed();
    while (seq_phase != PH_IDLE) send_item(FUNC_TICK, seq_phase != PH_WELL, 1'b0);
  endtask

  // stop offering items, let every result come back, then a little margin
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // cfg_valid stays high across back-to-back writes
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_STEP_PERIOD: settings.step_period_ms = data[7:0];
      REG_PAUSE_EVERY: settings.pause_every_turns = data[7:0];
      REG_PAUSE_MS:    settings.pause_ms = data[15:0];
      REG_MINOR_EVERY: settings.minor_jam_every = data[11:0];
      REG_VIB_EVERY:   settings.vibrate_jam_every = data[11:0];
      REG_MAX_TURNS:   settings.max_turns = data[15:0];
      REG_SETTLE_MS:   settings.settle_window_ms = data[15:0];
      REG_RETRIEVE_MS: settings.retrieval_window_ms = data[19:0];
      default: begin
      end
    endcase
  endtask

  task automatic apply_config(logic [7:0] step_len, logic [7:0] pause_every,
                              logic [15:0] pause_len, logic [11:0] minor_every,
                              logic [11:0] vib_every, logic [15:0] turn_limit,
                              logic [15:0] settle_len, logic [19:0] retrieve_len);
    drain_results();
    write_reg(REG_STEP_PERIOD, step_len);
    write_reg(REG_PAUSE_EVERY, pause_every);
    write_reg(REG_PAUSE_MS, pause_len);
    write_reg(REG_MINOR_EVERY, minor_every);
    write_reg(REG_VIB_EVERY, vib_every);
    write_reg(REG_MAX_TURNS, turn_limit);
    write_reg(REG_SETTLE_MS, settle_len);
    write_reg(REG_RETRIEVE_MS, retrieve_len);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // random feeds shaped by the predicted phase, with a share of pure noise
  task automatic run_feeds(int count, int noise_pct);
    func_t op;
    logic  sensed;
    logic  over;
    repeat (count) begin
      sensed = 1'b0;
      over = 1'b0;
      if ($urandom_range(0, 99) < noise_pct) begin
        op = func_t'($urandom_range(0, 3));
        sensed = 1'($urandom_range(0, 1));
        over = 1'($urandom_range(0, 1));
      end else begin
        case (seq_phase)
          PH_IDLE: begin
            op = ($urandom_range(0, 3) == 0) ? FUNC_LATE : FUNC_START;
            sensed = ($urandom_range(0, 3) == 0);
          end
          PH_DISP, PH_PAUSE, PH_PAUSE_RDY: begin
            op = FUNC_TICK;
            sensed = ($urandom_range(0, 7) == 0);
            over = ($urandom_range(0, 15) == 0);
          end
          PH_SETTLE: begin
            op = FUNC_TICK;
            sensed = ($urandom_range(0, 2) == 0);
          end
          default: begin
            // pellet sits in the well for a while, then is taken
            op = FUNC_TICK;
            sensed = ($urandom_range(0, 5) != 0);
          end
        endcase
      end
      send_item(op, sensed, over);
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset settings: idle items, nop, start while busy, override drop, taken
  task automatic test_idle_and_start();
    send_item(FUNC_TICK, 1'b1, 1'b1);
    send_item(FUNC_LATE, 1'b0, 1'b0);
    send_item(FUNC_NOP, 1'b1, 1'b1);
    send_item(FUNC_START, 1'b0, 1'b0);
    send_item(FUNC_START, 1'b1, 1'b1);
    send_ticks(1, 1'b0, 1'b0);
    send_ticks(2, 1'b0, 1'b1);
    send_ticks(2, 1'b1, 1'b0);
    send_ticks(1, 1'b0, 1'b0);
    complete_feed();
  endtask

  // pellet seen on a pause turn, pellet never reaching the well, then a jam
  // that lands on a pause and both jam-clear multiples
  task automatic test_pause_and_jam();
    apply_config(8'd1, 8'd2, 16'd1, 12'd2, 12'd4, 16'd3, 16'd2, 20'd2);
    send_item(FUNC_START, 1'b0, 1'b0);
    send_ticks(1, 1'b0, 1'b0);
    send_ticks(1, 1'b1, 1'b0);
    send_ticks(3, 1'b0, 1'b0);
    send_item(FUNC_START, 1'b0, 1'b0);
    send_ticks(4, 1'b0, 1'b0);
    send_ticks(1, 1'b1, 1'b0);
    complete_feed();
  endtask

  // removal overdue, late check with the pellet still there, then a start
  // that reports the late removal
  task automatic test_late_retrieval();
    send_item(FUNC_START, 1'b0, 1'b0);
    send_ticks(5, 1'b1, 1'b0);
    send_ticks(1, 1'b0, 1'b0);
    send_item(FUNC_LATE, 1'b1, 1'b0);
    send_item(FUNC_START, 1'b0, 1'b0);
    complete_feed();
  endtask

  // zero step period, zero pause length, zero jam multiples, zero settle window
  task automatic test_zero_settings();
    apply_config(8'd0, 8'd1, 16'd0, 12'd0, 12'd0, 16'd4, 16'd0, 20'd1);
    send_item(FUNC_START, 1'b0, 1'b0);
    send_ticks(2, 1'b0, 1'b0);
    send_ticks(1, 1'b0, 1'b1);
    send_ticks(2, 1'b0, 1'b0);
    complete_feed();
  endtask

  // top register values, then a burst of plain ticks with no idling
  task automatic test_extreme_settings();
    apply_config(8'd255, 8'd1, 16'd65535, 12'd4095, 12'd4095, 16'd65535,
                 16'd65535, 20'd1048575);
    send_item(FUNC_START, 1'b0, 1'b0);
    send_ticks(3, 1'b0, 1'b0);
    // rewriting the multiples mid-pause; a zero pause length ends it at once
    apply_config(8'd1, 8'd255, 16'd0, 12'd4095, 12'd4095, 16'd65535,
                 16'd65535, 20'd1048575);
    tx_gap_max = 0;
    rx_stall_max = 0;
    send_ticks(BURST_TICKS, 1'b0, 1'b0);
    complete_feed();
    tx_gap_max = 10;
    rx_stall_max = 10;
  endtask

  // result side held for a long stretch while items keep coming
  task automatic test_backpressure();
    apply_config(8'd1, 8'd5, 16'd2, 12'd3, 12'd7, 16'd20, 16'd4, 20'd6);
    tx_gap_max = 0;
    long_hold_req = 1'b1;
    run_feeds(40, 10);
    tx_gap_max = 10;
  endtask

  task automatic test_random_feeds();
    for (int set = 0; set < 5; set++) begin
      case (set)
        1: apply_config(8'd1, 8'd1, 16'd0, 12'd1, 12'd1, 16'd1, 16'd1, 20'd1);
        2: apply_config(8'd0, 8'd0, 16'd0, 12'd0, 12'd0, 16'($urandom_range(3, 40)),
                        16'd0, 20'($urandom_range(1, 10)));
        default: apply_config(8'($urandom_range(1, 4)), 8'($urandom_range(1, 12)),
                              16'($urandom_range(0, 6)), 12'($urandom_range(1, 8)),
                              12'($urandom_range(1, 12)), 16'($urandom_range(3, 40)),
                              16'($urandom_range(1, 8)), 20'($urandom_range(1, 10)));
      endcase
      // one stretch with no idling on either side
      if (set == 3) begin
        tx_gap_max = 0;
        rx_stall_max = 0;
      end
      run_feeds(RANDOM_ITEMS, 10);
      tx_gap_max = 10;
      rx_stall_max = 10;
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    settings.step_period_ms = RST_STEP_PERIOD;
    settings.pause_every_turns = RST_PAUSE_EVERY;
    settings.pause_ms = RST_PAUSE_MS;
    settings.minor_jam_every = RST_MINOR_EVERY;
    settings.vibrate_jam_every = RST_VIB_EVERY;
    settings.max_turns = RST_MAX_TURNS;
    settings.settle_window_ms = RST_SETTLE_MS;
    settings.retrieval_window_ms = RST_RETRIEVE_MS;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_and_start();
    test_pause_and_jam();
    test_late_retrieval();
    test_zero_settings();
    test_extreme_settings();
    test_backpressure();
    test_random_feeds();

    drain_results();
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
